/* rtl/ecu_pkg.sv */
// ecu_pkg: shared types and constants for the easing curve unit.
// No dependencies; used by the channel interfaces and by easing_curve_unit.
package ecu_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COS_DEPTH_DEF = 256;
  localparam int MODE_W        = 2;

  typedef longint unsigned u64_t;
  typedef longint          s64_t;

  // pi in Q2.30
  localparam u64_t PI_Q30 = 64'd3373259426;

  typedef enum logic [MODE_W-1:0] {
    MODE_IN_SINE     = 2'd0,
    MODE_INOUT_QUINT = 2'd1,
    MODE_OUT_BOUNCE  = 2'd2,
    MODE_IN_BOUNCE   = 2'd3
  } curve_mode_t;

  // bounce segment chosen by 11*n
  typedef enum logic [1:0] {
    PIECE_RISE   = 2'd0,
    PIECE_BIG    = 2'd1,
    PIECE_MID    = 2'd2,
    PIECE_SMALL  = 2'd3
  } bounce_piece_t;

endpackage

/* rtl/ecu_if.sv */
// ecu_if: valid/ready channels of the easing curve unit (progress in,
// eased value out, curve mode configuration). Depends on ecu_pkg.
interface ecu_progress_if #(parameter int W = ecu_pkg::FRAC_BITS_DEF + 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] progress;
  modport source (output valid, output progress, input ready);
  modport sink   (input valid, input progress, output ready);
endinterface

interface ecu_eased_if #(parameter int W = ecu_pkg::FRAC_BITS_DEF + 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] eased_value;
  modport source (output valid, output eased_value, input ready);
  modport sink   (input valid, input eased_value, output ready);
endinterface

interface ecu_mode_if;
  logic                        valid;
  logic                        ready;
  logic [ecu_pkg::MODE_W-1:0]  curve_mode;
  modport source (output valid, output curve_mode, input ready);
  modport sink   (input valid, input curve_mode, output ready);
endinterface

/* rtl/easing_curve_unit.sv */
// easing_curve_unit: pipelined easing curve evaluator (sine, quintic, bounce).
// Depends on ecu_pkg and the channel interfaces in ecu_if.sv.
//
// Usage:
//   in_chan  carries a progress value, unsigned with FRAC_BITS fraction bits;
//            values above one are treated as one.
//   out_chan carries the eased value in the same format, clamped to 0..one.
//   cfg_chan writes the curve mode (sine in, quintic in-out, bounce out,
//            bounce in); it is always ready and takes effect for items
//            accepted after the write.
// Seven register stages, s1 to s7: a result is offered on out_chan once its
// progress value has passed through all of them. One transaction per cycle
// is sustained while out_chan.ready stays high; the depth is set by the quintic
// curve, which chains four multiplies, each in a stage of its own.
// Each stage carries a valid bit and advances when the stage after it is
// empty or moving, so bubbles close up. When the receiver stalls, the full
// stages hold their data and in_chan.ready drops only once every stage is
// occupied; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and sets the mode to
// sine in. The cosine table is constant logic built at elaboration.
module easing_curve_unit #(
  parameter int FRAC_BITS       = ecu_pkg::FRAC_BITS_DEF,
  parameter int COS_TABLE_DEPTH = ecu_pkg::COS_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  ecu_progress_if.sink       in_chan,
  ecu_eased_if.source        out_chan,
  ecu_mode_if.sink           cfg_chan
);

  localparam int W    = FRAC_BITS + 1;          // field width
  localparam int IDXW = $clog2(COS_TABLE_DEPTH + 1);
  localparam int POSW = FRAC_BITS + IDXW;
  localparam int NW   = W + 4;                  // holds 22 * one
  localparam int TW   = W + 2;                  // bounce distance
  localparam int TTW  = 2 * TW;
  localparam int MW   = 2 * W;
  localparam int PW   = W + FRAC_BITS;
  localparam int NSTG = 7;

  localparam logic [W-1:0]    ONE      = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [W:0]      TWO_ONE  = {2'b10, {FRAC_BITS{1'b0}}};
  localparam logic [IDXW-1:0] DEPTH_I  = IDXW'(COS_TABLE_DEPTH);
  localparam logic [NW-1:0]   K4       = NW'(4) << FRAC_BITS;
  localparam logic [NW-1:0]   K6       = NW'(6) << FRAC_BITS;
  localparam logic [NW-1:0]   K8       = NW'(8) << FRAC_BITS;
  localparam logic [NW-1:0]   K9       = NW'(9) << FRAC_BITS;
  localparam logic [NW-1:0]   K10      = NW'(10) << FRAC_BITS;
  localparam logic [NW-1:0]   K21      = NW'(21) << FRAC_BITS;
  localparam logic [TTW:0]    HALF4    = (TTW + 1)'(1) << (FRAC_BITS + 3);
  localparam logic [TTW:0]    HALF6    = (TTW + 1)'(1) << (FRAC_BITS + 5);
  localparam logic [W:0]      OFF_BIG  = (W + 1)'((ecu_pkg::u64_t'(3) << FRAC_BITS) / 4);
  localparam logic [W:0]      OFF_MID  = (W + 1)'((ecu_pkg::u64_t'(15) << FRAC_BITS) / 16);
  localparam logic [W:0]      OFF_SML  = (W + 1)'((ecu_pkg::u64_t'(63) << FRAC_BITS) / 64);

  // ---------------------------------------------------------------------
  // Cosine quarter-wave table: Q2.30 Taylor series, rounded to FRAC_BITS
  // ---------------------------------------------------------------------
  logic [W-1:0] cos_tab [0:COS_TABLE_DEPTH];

  for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_cos
    localparam ecu_pkg::u64_t X  = (ecu_pkg::u64_t'(k) * ecu_pkg::PI_Q30) /
                                   ecu_pkg::u64_t'(2 * COS_TABLE_DEPTH);
    localparam ecu_pkg::u64_t X2 = (X * X) >> 30;
    localparam ecu_pkg::u64_t T0 = ecu_pkg::u64_t'(1) << 30;
    localparam ecu_pkg::u64_t T1 = ((T0 * X2) >> 30) / 2;
    localparam ecu_pkg::u64_t T2 = ((T1 * X2) >> 30) / 12;
    localparam ecu_pkg::u64_t T3 = ((T2 * X2) >> 30) / 30;
    localparam ecu_pkg::u64_t T4 = ((T3 * X2) >> 30) / 56;
    localparam ecu_pkg::u64_t T5 = ((T4 * X2) >> 30) / 90;
    localparam ecu_pkg::u64_t T6 = ((T5 * X2) >> 30) / 132;
    localparam ecu_pkg::u64_t T7 = ((T6 * X2) >> 30) / 182;
    localparam ecu_pkg::u64_t T8 = ((T7 * X2) >> 30) / 240;
    localparam ecu_pkg::u64_t T9 = ((T8 * X2) >> 30) / 306;
    localparam ecu_pkg::u64_t T10 = ((T9 * X2) >> 30) / 380;
    localparam ecu_pkg::s64_t SUM =
      ecu_pkg::s64_t'(T0) - ecu_pkg::s64_t'(T1) + ecu_pkg::s64_t'(T2) -
      ecu_pkg::s64_t'(T3) + ecu_pkg::s64_t'(T4) - ecu_pkg::s64_t'(T5) +
      ecu_pkg::s64_t'(T6) - ecu_pkg::s64_t'(T7) + ecu_pkg::s64_t'(T8) -
      ecu_pkg::s64_t'(T9) + ecu_pkg::s64_t'(T10);
    localparam ecu_pkg::u64_t SUMC = (SUM < 0) ? ecu_pkg::u64_t'(0) : ecu_pkg::u64_t'(SUM);
    localparam ecu_pkg::u64_t ENT  = ((SUMC << FRAC_BITS) + (ecu_pkg::u64_t'(1) << 29)) >> 30;
    assign cos_tab[k] = W'(ENT);
  end

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  ecu_pkg::curve_mode_t mode_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ecu_pkg::MODE_IN_SINE;
    end else if (cfg_chan.valid) begin
      mode_r <= ecu_pkg::curve_mode_t'(cfg_chan.curve_mode);
    end
  end

  // ---------------------------------------------------------------------
  // Stage control: valid bit per stage, advance when the next stage frees
  // ---------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] stg_en;

  always_comb begin
    stg_en[NSTG-1] = !vld_r[NSTG-1] || out_chan.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      stg_en[i] = !vld_r[i] || stg_en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stg_en[0]) vld_r[0] <= in_chan.valid;
      for (int i = 1; i < NSTG; i++) begin
        if (stg_en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign in_chan.ready = stg_en[0];

  // ---------------------------------------------------------------------
  // Stage 1: capture
  // ---------------------------------------------------------------------
  logic [W-1:0]         s1_n_r;
  ecu_pkg::curve_mode_t s1_mode_r;

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      s1_n_r    <= in_chan.progress;
      s1_mode_r <= mode_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: saturate, table index, quintic base, bounce segment
  // ---------------------------------------------------------------------
  logic [W-1:0]            n_sat;
  logic [POSW-1:0]         pos;
  logic [IDXW-1:0]         idx;
  logic [W:0]              two_n;
  logic [W-1:0]            nb;
  logic [NW-1:0]           n11;
  logic [NW-1:0]           n22;
  logic                    s2_upper_nxt;
  logic [W-1:0]            s2_m_nxt;
  logic [IDXW-1:0]         s2_ia_nxt;
  logic [IDXW-1:0]         s2_ib_nxt;
  ecu_pkg::bounce_piece_t  s2_piece_nxt;
  logic [TW-1:0]           s2_t_nxt;

  always_comb begin
    n_sat = (s1_n_r > ONE) ? ONE : s1_n_r;

    pos = POSW'(n_sat) * POSW'(COS_TABLE_DEPTH);
    idx = pos[POSW-1:FRAC_BITS];
    if (idx >= DEPTH_I) begin
      s2_ia_nxt = DEPTH_I;
      s2_ib_nxt = DEPTH_I;
    end else begin
      s2_ia_nxt = idx;
      s2_ib_nxt = idx + IDXW'(1);
    end

    two_n        = {n_sat, 1'b0};
    s2_upper_nxt = n_sat[FRAC_BITS] || n_sat[FRAC_BITS-1];
    s2_m_nxt     = s2_upper_nxt ? W'(TWO_ONE - two_n) : W'(two_n);

    // in-bounce evaluates the out-bounce curve at one minus n
    nb  = (s1_mode_r == ecu_pkg::MODE_IN_BOUNCE) ? (ONE - n_sat) : n_sat;
    n11 = NW'(nb) * NW'(11);
    n22 = n11 << 1;
    priority if (n11 < K4) begin
      s2_piece_nxt = ecu_pkg::PIECE_RISE;
      s2_t_nxt     = TW'(n11);
    end else if (n11 < K8) begin
      s2_piece_nxt = ecu_pkg::PIECE_BIG;
      s2_t_nxt     = (n11 >= K6) ? TW'(n11 - K6) : TW'(K6 - n11);
    end else if (n11 < K10) begin
      s2_piece_nxt = ecu_pkg::PIECE_MID;
      s2_t_nxt     = (n11 >= K9) ? TW'(n11 - K9) : TW'(K9 - n11);
    end else begin
      s2_piece_nxt = ecu_pkg::PIECE_SMALL;
      s2_t_nxt     = (n22 >= K21) ? TW'(n22 - K21) : TW'(K21 - n22);
    end
  end

  ecu_pkg::curve_mode_t    s2_mode_r;
  logic                    s2_upper_r;
  logic [W-1:0]            s2_m_r;
  logic [IDXW-1:0]         s2_ia_r;
  logic [IDXW-1:0]         s2_ib_r;
  logic [FRAC_BITS-1:0]    s2_frac_r;
  ecu_pkg::bounce_piece_t  s2_piece_r;
  logic [TW-1:0]           s2_t_r;

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      s2_mode_r  <= s1_mode_r;
      s2_upper_r <= s2_upper_nxt;
      s2_m_r     <= s2_m_nxt;
      s2_ia_r    <= s2_ia_nxt;
      s2_ib_r    <= s2_ib_nxt;
      s2_frac_r  <= pos[FRAC_BITS-1:0];
      s2_piece_r <= s2_piece_nxt;
      s2_t_r     <= s2_t_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: table lookup, m^2, bounce square
  // ---------------------------------------------------------------------
  logic [W-1:0]  tab_a;
  logic [W-1:0]  tab_b;
  logic [W-1:0]  s3_d_nxt;
  logic [MW-1:0] mul3;
  logic [W-1:0]  s3_p_nxt;
  logic [TTW-1:0] s3_tt_nxt;

  always_comb begin
    tab_a     = cos_tab[s2_ia_r];
    tab_b     = cos_tab[s2_ib_r];
    s3_d_nxt  = (tab_a >= tab_b) ? (tab_a - tab_b) : '0;
    mul3      = MW'(s2_m_r) * MW'(s2_m_r);
    s3_p_nxt  = W'(mul3 >> FRAC_BITS);
    s3_tt_nxt = TTW'(s2_t_r) * TTW'(s2_t_r);
  end

  ecu_pkg::curve_mode_t    s3_mode_r;
  logic                    s3_upper_r;
  logic [W-1:0]            s3_m_r;
  logic [W-1:0]            s3_p_r;
  logic [W-1:0]            s3_a_r;
  logic [W-1:0]            s3_d_r;
  logic [FRAC_BITS-1:0]    s3_frac_r;
  ecu_pkg::bounce_piece_t  s3_piece_r;
  logic [TTW-1:0]          s3_tt_r;

  always_ff @(posedge clk) begin
    if (stg_en[2]) begin
      s3_mode_r  <= s2_mode_r;
      s3_upper_r <= s2_upper_r;
      s3_m_r     <= s2_m_r;
      s3_p_r     <= s3_p_nxt;
      s3_a_r     <= tab_a;
      s3_d_r     <= s3_d_nxt;
      s3_frac_r  <= s2_frac_r;
      s3_piece_r <= s2_piece_r;
      s3_tt_r    <= s3_tt_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: interpolation product, m^3, bounce value
  // ---------------------------------------------------------------------
  logic [PW-1:0]  s4_prod_nxt;
  logic [MW-1:0]  mul4;
  logic [W-1:0]   s4_p_nxt;
  logic [TTW:0]   rnd4;
  logic [TTW:0]   rnd6;
  logic [W:0]     bv;
  logic [W-1:0]   bv_cl;
  logic [W-1:0]   s4_bres_nxt;

  always_comb begin
    s4_prod_nxt = PW'(s3_d_r) * PW'(s3_frac_r);
    mul4        = MW'(s3_p_r) * MW'(s3_m_r);
    s4_p_nxt    = W'(mul4 >> FRAC_BITS);

    rnd4 = ((TTW + 1)'(s3_tt_r) + HALF4) >> (FRAC_BITS + 4);
    rnd6 = ((TTW + 1)'(s3_tt_r) + HALF6) >> (FRAC_BITS + 6);
    unique case (s3_piece_r)
      ecu_pkg::PIECE_RISE:  bv = (W + 1)'(rnd4);
      ecu_pkg::PIECE_BIG:   bv = (W + 1)'(rnd4) + OFF_BIG;
      ecu_pkg::PIECE_MID:   bv = (W + 1)'(rnd4) + OFF_MID;
      ecu_pkg::PIECE_SMALL: bv = (W + 1)'(rnd6) + OFF_SML;
      default:              bv = '0;
    endcase
    bv_cl       = (bv > (W + 1)'(ONE)) ? ONE : W'(bv);
    s4_bres_nxt = (s3_mode_r == ecu_pkg::MODE_IN_BOUNCE) ? (ONE - bv_cl) : bv_cl;
  end

  ecu_pkg::curve_mode_t s4_mode_r;
  logic                 s4_upper_r;
  logic [W-1:0]         s4_m_r;
  logic [W-1:0]         s4_p_r;
  logic [W-1:0]         s4_a_r;
  logic [PW-1:0]        s4_prod_r;
  logic [W-1:0]         s4_bres_r;

  always_ff @(posedge clk) begin
    if (stg_en[3]) begin
      s4_mode_r  <= s3_mode_r;
      s4_upper_r <= s3_upper_r;
      s4_m_r     <= s3_m_r;
      s4_p_r     <= s4_p_nxt;
      s4_a_r     <= s3_a_r;
      s4_prod_r  <= s4_prod_nxt;
      s4_bres_r  <= s4_bres_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: sine result, m^4
  // ---------------------------------------------------------------------
  logic [W-1:0]  cosv;
  logic [W-1:0]  sres;
  logic [MW-1:0] mul5;
  logic [W-1:0]  s5_p_nxt;
  logic [W-1:0]  s5_res_nxt;

  always_comb begin
    cosv       = s4_a_r - W'(s4_prod_r >> FRAC_BITS);
    sres       = (cosv >= ONE) ? '0 : (ONE - cosv);
    mul5       = MW'(s4_p_r) * MW'(s4_m_r);
    s5_p_nxt   = W'(mul5 >> FRAC_BITS);
    s5_res_nxt = (s4_mode_r == ecu_pkg::MODE_IN_SINE) ? sres : s4_bres_r;
  end

  ecu_pkg::curve_mode_t s5_mode_r;
  logic                 s5_upper_r;
  logic [W-1:0]         s5_m_r;
  logic [W-1:0]         s5_p_r;
  logic [W-1:0]         s5_res_r;

  always_ff @(posedge clk) begin
    if (stg_en[4]) begin
      s5_mode_r  <= s4_mode_r;
      s5_upper_r <= s4_upper_r;
      s5_m_r     <= s4_m_r;
      s5_p_r     <= s5_p_nxt;
      s5_res_r   <= s5_res_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: m^5
  // ---------------------------------------------------------------------
  logic [MW-1:0] mul6;
  logic [W-1:0]  s6_p_nxt;

  assign mul6     = MW'(s5_p_r) * MW'(s5_m_r);
  assign s6_p_nxt = W'(mul6 >> FRAC_BITS);

  ecu_pkg::curve_mode_t s6_mode_r;
  logic                 s6_upper_r;
  logic [W-1:0]         s6_p_r;
  logic [W-1:0]         s6_res_r;

  always_ff @(posedge clk) begin
    if (stg_en[5]) begin
      s6_mode_r  <= s5_mode_r;
      s6_upper_r <= s5_upper_r;
      s6_p_r     <= s6_p_nxt;
      s6_res_r   <= s5_res_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: quintic fold, final clamp, output register
  // ---------------------------------------------------------------------
  logic [W-1:0] qhalf;
  logic [W-1:0] qres;
  logic [W-1:0] fres;
  logic [W-1:0] s7_res_nxt;
  logic [W-1:0] s7_res_r;

  always_comb begin
    qhalf = s6_p_r >> 1;
    qres  = s6_upper_r ? (ONE - qhalf) : qhalf;
    unique case (s6_mode_r)
      ecu_pkg::MODE_INOUT_QUINT: fres = qres;
      ecu_pkg::MODE_IN_SINE,
      ecu_pkg::MODE_OUT_BOUNCE,
      ecu_pkg::MODE_IN_BOUNCE:   fres = s6_res_r;
      default:                   fres = s6_res_r;
    endcase
    s7_res_nxt = (fres > ONE) ? ONE : fres;
  end

  always_ff @(posedge clk) begin
    if (stg_en[6]) begin
      s7_res_r <= s7_res_nxt;
    end
  end

  assign out_chan.valid       = vld_r[NSTG-1];
  assign out_chan.eased_value = s7_res_r;

`ifndef SYNTHESIS
  a_out_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.eased_value <= ONE))
    else $error("eased value above one");

  a_ready_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> ((&vld_r) && !out_chan.ready))
    else $error("input stalled while a stage is free");

  a_occupancy_step : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      (($countones(vld_r) <= $past($countones(vld_r)) + 1) &&
       ($countones(vld_r) + 1 >= $past($countones(vld_r)))))
    else $error("pipeline occupancy jumped by more than one");

  a_no_bubble_after_take : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && vld_r[NSTG-2]) |=> out_chan.valid)
    else $error("queued result lost after a transaction");
`endif

endmodule
